/* sv/bgr_quad_to_yuv420_semiplanar_macros.svh */
// Assertion shorthands, clocked on clk and disabled while arst_n is low
`ifndef BGR_QUAD_TO_YUV420_SEMIPLANAR_MACROS_SVH
`define BGR_QUAD_TO_YUV420_SEMIPLANAR_MACROS_SVH

`define BQY_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bqy assertion failed");

`define BQY_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bqy assertion failed");

`endif

/* sv/bqy_pkg.sv */
package bqy_pkg;

	localparam int MAX_DIM_DEF        = 4096;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int CFG_DATA_W         = 13;
	localparam int CFG_IDX_W          = 2;
	localparam int PIXEL_W            = 24;
	localparam int BLOCK_W            = 11;
	localparam int ADDR_W             = 24;
	localparam int FRAME_WIDTH_RESET  = 1920;
	localparam int FRAME_HEIGHT_RESET = 1080;

	localparam int COEF_Y_B_MILLI = 114;
	localparam int COEF_Y_G_MILLI = 587;
	localparam int COEF_Y_R_MILLI = 299;
	localparam int COEF_U_MILLI   = 492;
	localparam int COEF_V_MILLI   = 877;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] top_left_pixel;
		logic [PIXEL_W-1:0] top_right_pixel;
		logic [PIXEL_W-1:0] bottom_left_pixel;
		logic [PIXEL_W-1:0] bottom_right_pixel;
		logic [BLOCK_W-1:0] block_col;
		logic [BLOCK_W-1:0] block_row;
	} quad_t;

	typedef struct packed {
		logic [7:0]        luma_top_left;
		logic [7:0]        luma_top_right;
		logic [7:0]        luma_bottom_left;
		logic [7:0]        luma_bottom_right;
		logic [7:0]        chroma_u;
		logic [7:0]        chroma_v;
		logic [ADDR_W-1:0] luma_address;
		logic [ADDR_W-1:0] chroma_address;
		logic              out_of_range;
	} yuv_result_t;

	// round to nearest, ties up
	function automatic longint fix_coef(input int milli, input int frac);
		return ((longint'(milli) << frac) + 64'sd500) / 1000;
	endfunction

endpackage

/* sv/bqy_lane.sv */
module bqy_lane
	import bqy_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	localparam int TERM_W = 2 * COEF_FRAC_BITS + 11
) (
	input  logic                     clk,
	input  logic [PIXEL_W-1:0]       pixel,
	output logic [7:0]               luma_s2,
	output logic signed [TERM_W-1:0] u_term_s2,
	output logic signed [TERM_W-1:0] v_term_s2
);

	localparam int F    = COEF_FRAC_BITS;
	localparam int Y_W  = F + 9;
	localparam int D_W  = F + 10;
	localparam longint CB = fix_coef(COEF_Y_B_MILLI, F);
	localparam longint CG = fix_coef(COEF_Y_G_MILLI, F);
	localparam longint CR = fix_coef(COEF_Y_R_MILLI, F);
	localparam longint CU = fix_coef(COEF_U_MILLI, F);
	localparam longint CV = fix_coef(COEF_V_MILLI, F);

	logic [Y_W-1:0]        y_c;
	logic [Y_W-1:0]        y_s1;
	logic [7:0]            b_s1;
	logic [7:0]            r_s1;
	logic signed [D_W-1:0] db_c;
	logic signed [D_W-1:0] dr_c;
	logic [Y_W-F-1:0]      y_int_c;
	logic [7:0]            luma_c;

	assign y_c = Y_W'(CB) * Y_W'(pixel[7:0]) + Y_W'(CG) * Y_W'(pixel[15:8])
		+ Y_W'(CR) * Y_W'(pixel[23:16]);

	always_ff @(posedge clk) begin
		y_s1 <= y_c;
		b_s1 <= pixel[7:0];
		r_s1 <= pixel[23:16];
	end

	assign db_c    = D_W'({b_s1, {F{1'b0}}}) - D_W'(y_s1);
	assign dr_c    = D_W'({r_s1, {F{1'b0}}}) - D_W'(y_s1);
	assign y_int_c = y_s1[Y_W-1:F];
	assign luma_c  = (y_int_c > (Y_W-F)'(255)) ? 8'd255 : y_int_c[7:0];

	always_ff @(posedge clk) begin
		luma_s2   <= luma_c;
		u_term_s2 <= TERM_W'(db_c) * TERM_W'(CU);
		v_term_s2 <= TERM_W'(dr_c) * TERM_W'(CV);
	end

endmodule

/* sv/bqy_merge.sv */
module bqy_merge
	import bqy_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	localparam int TERM_W = 2 * COEF_FRAC_BITS + 11
) (
	input  logic                     clk,
	input  logic signed [TERM_W-1:0] u_term [4],
	input  logic signed [TERM_W-1:0] v_term [4],
	output logic [7:0]               chroma_u_s3,
	output logic [7:0]               chroma_v_s3
);

	localparam int SUM_W = TERM_W + 3;
	localparam int SHIFT = 2 * COEF_FRAC_BITS + 2;
	localparam logic signed [SUM_W-1:0] OFFSET = SUM_W'(128) << SHIFT;

	logic signed [SUM_W-1:0] u_sum_c;
	logic signed [SUM_W-1:0] v_sum_c;
	logic signed [SUM_W-1:0] u_q_c;
	logic signed [SUM_W-1:0] v_q_c;
	logic [7:0]              u_c;
	logic [7:0]              v_c;

	assign u_sum_c = SUM_W'(u_term[0]) + SUM_W'(u_term[1]) + SUM_W'(u_term[2])
		+ SUM_W'(u_term[3]) + OFFSET;
	assign v_sum_c = SUM_W'(v_term[0]) + SUM_W'(v_term[1]) + SUM_W'(v_term[2])
		+ SUM_W'(v_term[3]) + OFFSET;
	assign u_q_c = u_sum_c >>> SHIFT;
	assign v_q_c = v_sum_c >>> SHIFT;

	always_comb begin
		if (u_sum_c < 0) begin
			u_c = 8'd0;
		end else if (u_q_c > SUM_W'(255)) begin
			u_c = 8'd255;
		end else begin
			u_c = u_q_c[7:0];
		end
		if (v_sum_c < 0) begin
			v_c = 8'd0;
		end else if (v_q_c > SUM_W'(255)) begin
			v_c = 8'd255;
		end else begin
			v_c = v_q_c[7:0];
		end
	end

	always_ff @(posedge clk) begin
		chroma_u_s3 <= u_c;
		chroma_v_s3 <= v_c;
	end

endmodule

/* sv/bqy_addr.sv */
module bqy_addr
	import bqy_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF,
	localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
	input  logic               clk,
	input  logic [DIM_W-1:0]   frame_width,
	input  logic [DIM_W-1:0]   frame_height,
	input  logic [BLOCK_W-1:0] block_col,
	input  logic [BLOCK_W-1:0] block_row,
	output logic [ADDR_W-1:0]  luma_address_s3,
	output logic [ADDR_W-1:0]  chroma_address_s3,
	output logic               out_of_range_s3
);

	localparam int HALF_W = DIM_W - 1;
	localparam int CMP_W  = (DIM_W > BLOCK_W) ? DIM_W : BLOCK_W;
	localparam int PROD_W = HALF_W + DIM_W;
	localparam int AW     = (PROD_W + 2 > ADDR_W) ? PROD_W + 2 : ADDR_W;

	logic [HALF_W-1:0]  half_w_c;
	logic [HALF_W-1:0]  half_h_c;
	logic               oor_c;
	logic [HALF_W-1:0]  pair_c;
	logic [HALF_W-1:0]  pair_s1;
	logic [BLOCK_W-1:0] col_s1;
	logic               oor_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [BLOCK_W-1:0] col_s2;
	logic               oor_s2;
	logic [AW-1:0]      luma_c;
	logic [AW-1:0]      chroma_c;

	assign half_w_c = frame_width[DIM_W-1:1];
	assign half_h_c = frame_height[DIM_W-1:1];
	assign oor_c    = (CMP_W'(block_row) >= CMP_W'(half_h_c))
		|| (CMP_W'(block_col) >= CMP_W'(half_w_c));
	assign pair_c   = HALF_W'(CMP_W'(half_h_c) - CMP_W'(block_row) - CMP_W'(1));

	always_ff @(posedge clk) begin
		oor_s1  <= oor_c;
		pair_s1 <= oor_c ? '0 : pair_c;
		col_s1  <= oor_c ? '0 : block_col;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(pair_s1) * PROD_W'(frame_width);
		col_s2  <= col_s1;
		oor_s2  <= oor_s1;
	end

	assign luma_c   = (AW'(prod_s2) << 1) + (AW'(col_s2) << 1);
	assign chroma_c = AW'(prod_s2) + (AW'(col_s2) << 1);

	always_ff @(posedge clk) begin
		luma_address_s3   <= luma_c[ADDR_W-1:0];
		chroma_address_s3 <= chroma_c[ADDR_W-1:0];
		out_of_range_s3   <= oor_s2;
	end

endmodule

/* sv/bgr_quad_to_yuv420_semiplanar.sv */
// done is the accepted start registered through valid_s1, valid_s2 and valid_s3.
// Throughput: one quad per cycle; busy stays low and up to three quads are in flight.
// Four pixel lanes run the luma and chroma multiplies; a merge stage sums the chroma terms.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the valid pipeline and loads frame_width 1920, frame_height 1080.
`include "bgr_quad_to_yuv420_semiplanar_macros.svh"

module bgr_quad_to_yuv420_semiplanar
	import bqy_pkg::*;
#(
	parameter int MAX_DIM        = MAX_DIM_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	input  quad_t                 item,
	output logic                  busy,
	output logic                  done,
	output yuv_result_t           result
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int TERM_W = 2 * COEF_FRAC_BITS + 11;
	localparam int FW_RST = (FRAME_WIDTH_RESET > MAX_DIM) ? MAX_DIM : FRAME_WIDTH_RESET;
	localparam int FH_RST = (FRAME_HEIGHT_RESET > MAX_DIM) ? MAX_DIM : FRAME_HEIGHT_RESET;

	logic [DIM_W-1:0]        frame_width_q;
	logic [DIM_W-1:0]        frame_height_q;
	logic [DIM_W-1:0]        cfg_sat_c;
	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic [PIXEL_W-1:0]      pixels [4];
	logic [7:0]              luma_s2 [4];
	logic [7:0]              luma_s3 [4];
	logic signed [TERM_W-1:0] u_term_s2 [4];
	logic signed [TERM_W-1:0] v_term_s2 [4];
	logic [7:0]              chroma_u_s3;
	logic [7:0]              chroma_v_s3;
	logic [ADDR_W-1:0]       luma_address_s3;
	logic [ADDR_W-1:0]       chroma_address_s3;
	logic                    out_of_range_s3;

	assign cfg_sat_c = (32'(cfg_data) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(FW_RST);
			frame_height_q <= DIM_W'(FH_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_sat_c;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_sat_c;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign pixels[0] = item.top_left_pixel;
	assign pixels[1] = item.top_right_pixel;
	assign pixels[2] = item.bottom_left_pixel;
	assign pixels[3] = item.bottom_right_pixel;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		bqy_lane #(
			.COEF_FRAC_BITS(COEF_FRAC_BITS)
		) u_lane (
			.clk       (clk),
			.pixel     (pixels[i]),
			.luma_s2   (luma_s2[i]),
			.u_term_s2 (u_term_s2[i]),
			.v_term_s2 (v_term_s2[i])
		);
	end

	always_ff @(posedge clk) begin
		luma_s3 <= luma_s2;
	end

	bqy_merge #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_merge (
		.clk         (clk),
		.u_term      (u_term_s2),
		.v_term      (v_term_s2),
		.chroma_u_s3 (chroma_u_s3),
		.chroma_v_s3 (chroma_v_s3)
	);

	bqy_addr #(
		.MAX_DIM(MAX_DIM)
	) u_addr (
		.clk               (clk),
		.frame_width       (frame_width_q),
		.frame_height      (frame_height_q),
		.block_col         (item.block_col),
		.block_row         (item.block_row),
		.luma_address_s3   (luma_address_s3),
		.chroma_address_s3 (chroma_address_s3),
		.out_of_range_s3   (out_of_range_s3)
	);

	assign done                     = valid_s3;
	assign result.luma_top_left     = luma_s3[0];
	assign result.luma_top_right    = luma_s3[1];
	assign result.luma_bottom_left  = luma_s3[2];
	assign result.luma_bottom_right = luma_s3[3];
	assign result.chroma_u          = chroma_u_s3;
	assign result.chroma_v          = chroma_v_s3;
	assign result.luma_address      = luma_address_s3;
	assign result.chroma_address    = chroma_address_s3;
	assign result.out_of_range      = out_of_range_s3;

	`BQY_ASSERT_IMP(a_done_follows_start, start && !busy, ##3 done)
	`BQY_ASSERT_IMP(a_done_has_source, done, $past(start && !busy, 3))
	`BQY_ASSERT_IMP(a_oor_zero_addr, done && result.out_of_range,
		(result.luma_address == '0) && (result.chroma_address == '0))
	`BQY_ASSERT_NEXT(a_pipe_advance, valid_s1, valid_s2)

endmodule

/* sim/bgr_quad_to_yuv420_semiplanar_tb.sv */
module bgr_quad_to_yuv420_semiplanar_tb
	import bqy_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = COEF_FRAC_BITS_DEF;
	localparam longint COEF_YB = ((longint'(COEF_Y_B_MILLI) << FRAC) + 500) / 1000;
	localparam longint COEF_YG = ((longint'(COEF_Y_G_MILLI) << FRAC) + 500) / 1000;
	localparam longint COEF_YR = ((longint'(COEF_Y_R_MILLI) << FRAC) + 500) / 1000;
	localparam longint COEF_U  = ((longint'(COEF_U_MILLI) << FRAC) + 500) / 1000;
	localparam longint COEF_V  = ((longint'(COEF_V_MILLI) << FRAC) + 500) / 1000;
	localparam int CHROMA_SHIFT = 2 * FRAC + 2;
	localparam longint CHROMA_BIAS = longint'(128) << CHROMA_SHIFT;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_QUADS = 150;
	localparam int RANDOM_PHASES = 11;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	quad_t                 item;
	logic                  busy;
	logic                  done;
	yuv_result_t           result;

	int model_width;
	int model_height;
	int mismatches = 0;
	yuv_result_t yuv_pending[$];
	yuv_result_t expected_yuv;

	bgr_quad_to_yuv420_semiplanar dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("bgr_quad_to_yuv420_semiplanar verification failed");
		$finish;
	end

	function automatic logic [7:0] clamp_byte(input longint v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic yuv_result_t convert_quad(input quad_t q);
		logic [PIXEL_W-1:0] px [4];
		logic [7:0] luma [4];
		longint blue, green, red, y_fix, u_acc, v_acc;
		longint half_w, half_h, col, row, pair;
		yuv_result_t r;
		px[0] = q.top_left_pixel;
		px[1] = q.top_right_pixel;
		px[2] = q.bottom_left_pixel;
		px[3] = q.bottom_right_pixel;
		u_acc = 0;
		v_acc = 0;
		for (int i = 0; i < 4; i++) begin
			blue = longint'(px[i][7:0]);
			green = longint'(px[i][15:8]);
			red = longint'(px[i][23:16]);
			y_fix = COEF_YB * blue + COEF_YG * green + COEF_YR * red;
			luma[i] = clamp_byte(y_fix >>> FRAC);
			u_acc += COEF_U * ((blue <<< FRAC) - y_fix);
			v_acc += COEF_V * ((red <<< FRAC) - y_fix);
		end
		r.luma_top_left = luma[0];
		r.luma_top_right = luma[1];
		r.luma_bottom_left = luma[2];
		r.luma_bottom_right = luma[3];
		r.chroma_u = clamp_byte((u_acc + CHROMA_BIAS) >>> CHROMA_SHIFT);
		r.chroma_v = clamp_byte((v_acc + CHROMA_BIAS) >>> CHROMA_SHIFT);
		half_w = longint'(model_width >> 1);
		half_h = longint'(model_height >> 1);
		col = longint'(q.block_col);
		row = longint'(q.block_row);
		r.out_of_range = (row >= half_h) || (col >= half_w);
		if (r.out_of_range) begin
			r.luma_address = '0;
			r.chroma_address = '0;
		end else begin
			pair = half_h - row - 1;
			r.luma_address = ADDR_W'(2 * pair * longint'(model_width) + 2 * col);
			r.chroma_address = ADDR_W'(pair * longint'(model_width) + 2 * col);
		end
		return r;
	endfunction

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [PIXEL_W-1:0] rand_pixel();
		if ($urandom_range(0, 2) == 0)
			return {rand_channel(), rand_channel(), rand_channel()};
		return PIXEL_W'($urandom);
	endfunction

	function automatic logic [BLOCK_W-1:0] rand_coord(input int half);
		case ($urandom_range(0, 9))
			0: return BLOCK_W'($urandom_range(0, 2047));
			1: return BLOCK_W'(half > 0 ? half - 1 : 0);
			2: return BLOCK_W'(half > 2047 ? 2047 : half);
			default: begin
				if (half > 0)
					return BLOCK_W'($urandom_range(0, half - 1));
				return BLOCK_W'($urandom_range(0, 2047));
			end
		endcase
	endfunction

	function automatic quad_t rand_quad();
		quad_t q;
		q.top_left_pixel = rand_pixel();
		q.top_right_pixel = rand_pixel();
		q.bottom_left_pixel = rand_pixel();
		q.bottom_right_pixel = rand_pixel();
		q.block_col = rand_coord(model_width >> 1);
		q.block_row = rand_coord(model_height >> 1);
		return q;
	endfunction

	function automatic quad_t make_quad(input logic [PIXEL_W-1:0] tl, tr, bl, br,
			input int col, row);
		quad_t q;
		q.top_left_pixel = tl;
		q.top_right_pixel = tr;
		q.bottom_left_pixel = bl;
		q.bottom_right_pixel = br;
		q.block_col = BLOCK_W'(col);
		q.block_row = BLOCK_W'(row);
		return q;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (yuv_pending.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, result);
				mismatches++;
			end else begin
				expected_yuv = yuv_pending.pop_front();
				check_field("luma_top_left", 32'(expected_yuv.luma_top_left),
					32'(result.luma_top_left));
				check_field("luma_top_right", 32'(expected_yuv.luma_top_right),
					32'(result.luma_top_right));
				check_field("luma_bottom_left", 32'(expected_yuv.luma_bottom_left),
					32'(result.luma_bottom_left));
				check_field("luma_bottom_right", 32'(expected_yuv.luma_bottom_right),
					32'(result.luma_bottom_right));
				check_field("chroma_u", 32'(expected_yuv.chroma_u), 32'(result.chroma_u));
				check_field("chroma_v", 32'(expected_yuv.chroma_v), 32'(result.chroma_v));
				check_field("luma_address", 32'(expected_yuv.luma_address),
					32'(result.luma_address));
				check_field("chroma_address", 32'(expected_yuv.chroma_address),
					32'(result.chroma_address));
				check_field("out_of_range", 32'(expected_yuv.out_of_range),
					32'(result.out_of_range));
			end
		end
	end

	task automatic send_quad(input quad_t q);
		start <= 1'b1;
		item <= q;
		do @(posedge clk); while (busy);
		yuv_pending.push_back(convert_quad(q));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (yuv_pending.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		int v;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		v = int'(val);
		if (v > MAX_DIM_DEF)
			v = MAX_DIM_DEF;
		if (idx == REG_FRAME_WIDTH)
			model_width = v;
		else if (idx == REG_FRAME_HEIGHT)
			model_height = v;
		@(posedge clk);
	endtask

	task automatic set_frame(input int w, h);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
	endtask

	task automatic run_quads(input int count, input bit bursty);
		int remaining;
		int burst;
		int gap;
		remaining = count;
		while (remaining > 0) begin
			burst = bursty ? $urandom_range(1, 24) : remaining;
			for (int i = 0; i < burst && remaining > 0; i++) begin
				send_quad(rand_quad());
				remaining--;
			end
			if (bursty && remaining > 0) begin
				if ($urandom_range(0, 19) == 0) begin
					drain_results();
				end else begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap > 0) begin
						start <= 1'b0;
						item <= rand_quad();
						repeat (gap) @(posedge clk);
					end
				end
			end
		end
		drain_results();
	endtask

	task automatic test_colour_extremes();
		send_quad(make_quad(24'h000000, 24'h000000, 24'h000000, 24'h000000, 0, 0));
		send_quad(make_quad(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 959, 539));
		send_quad(make_quad(24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF, 1, 1));
		send_quad(make_quad(24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 2, 3));
		send_quad(make_quad(24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 958, 0));
		send_quad(make_quad(24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 0, 538));
		send_quad(make_quad(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 100, 200));
		send_quad(make_quad(24'hFF0000, 24'h0000FF, 24'h00FF00, 24'h000000, 960, 0));
		send_quad(make_quad(24'h123456, 24'h654321, 24'hABCDEF, 24'hFEDCBA, 0, 540));
		send_quad(make_quad(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 2047, 2047));
		send_quad(make_quad(24'h00FF00, 24'h00FF00, 24'hFF0000, 24'hFF0000, 1024, 1024));
		drain_results();
	endtask

	task automatic test_frame_registers();
		set_frame(2, 2);
		send_quad(make_quad(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 0, 0));
		send_quad(make_quad(24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF, 1, 0));
		send_quad(make_quad(24'h00FF00, 24'h000000, 24'hFF00FF, 24'h0000FF, 0, 1));
		drain_results();
		set_frame(8191, 8191);
		send_quad(make_quad(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 2047, 2047));
		send_quad(make_quad(24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE, 2047, 0));
		send_quad(make_quad(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 0, 2047));
		drain_results();
		set_frame(1, 0);
		send_quad(make_quad(24'h336699, 24'h996633, 24'h000000, 24'hFFFFFF, 0, 0));
		drain_results();
		set_frame(4096, 3);
		write_reg(REG_SPARE_A, 13'd100);
		write_reg(REG_SPARE_B, 13'h1FFF);
		send_quad(make_quad(24'h102030, 24'h405060, 24'h708090, 24'hA0B0C0, 2047, 0));
		send_quad(make_quad(24'h102030, 24'h405060, 24'h708090, 24'hA0B0C0, 5, 1));
		drain_results();
	endtask

	task automatic test_random_stream();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: set_frame(4096, 4096);
				1: set_frame(2, 2);
				2: set_frame(8191, 6000);
				3: set_frame(3, 4095);
				4: set_frame(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET);
				5: set_frame(1, 4096);
				6: set_frame(4096, 2);
				default: set_frame($urandom_range(2, 4096), $urandom_range(2, 4096));
			endcase
			run_quads(PHASE_QUADS, phase != 4);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		start <= 1'b0;
		item <= '0;
		model_width = FRAME_WIDTH_RESET;
		model_height = FRAME_HEIGHT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_colour_extremes();
		test_frame_registers();
		test_random_stream();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && yuv_pending.size() == 0)
			$display("bgr_quad_to_yuv420_semiplanar verification clean");
		else
			$display("bgr_quad_to_yuv420_semiplanar verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/bqy_pkg.sv
sv/bqy_lane.sv
sv/bqy_merge.sv
sv/bqy_addr.sv
sv/bgr_quad_to_yuv420_semiplanar.sv
sim/bgr_quad_to_yuv420_semiplanar_tb.sv
